>>> hw/rtl/epc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epc_pkg: shared types and constants of the epoch-to-calendar converter
// Unit lengths in seconds, conversion phases, leap-year test and month table.
// ----------------------------------------------------------------------------
package epc_pkg;

    localparam int unsigned SecW = 31;

    typedef logic [SecW-1:0] t_secs;
    typedef logic [2:0]      t_phase;

    // Conversion phases, walked in this order
    localparam t_phase PH_YEAR  = 3'd0;
    localparam t_phase PH_MONTH = 3'd1;
    localparam t_phase PH_DAY   = 3'd2;
    localparam t_phase PH_HOUR  = 3'd3;
    localparam t_phase PH_MIN   = 3'd4;

    localparam t_secs SECS_PER_MIN   = 31'd60;
    localparam t_secs SECS_PER_HOUR  = 31'd3600;
    localparam t_secs SECS_PER_DAY   = 31'd86400;
    localparam t_secs SECS_YEAR      = 31'd31536000;
    localparam t_secs SECS_LEAP_YEAR = 31'd31622400;

    localparam logic [7:0] EPOCH_YEAR = 8'd70;
    localparam logic [3:0] MONTH_LAST = 4'd11;

    // Length selection handed to the shared subtract unit
    typedef struct packed {
        t_secs len;
        logic  allow;
    } t_len_sel;

    // Result of one compare-and-subtract step
    typedef struct packed {
        logic  take;
        t_secs diff;
    } t_sub_res;

    // Leap test on a year counted from 1900. Over the 8-bit range the
    // centuries are 1900, 2000 and 2100; only 2000 divides by 400.
    function automatic logic leap_of(input logic [7:0] yr);
        logic div4;
        logic bad_century;
        div4        = (yr[1:0] == 2'b00);
        bad_century = (yr == 8'd0) || (yr == 8'd200);
        return div4 && !bad_century;
    endfunction

    // Month length in seconds, February stretched in a leap year
    function automatic t_secs month_secs(input logic [3:0] mon, input logic leap);
        t_secs len;
        unique case (mon)
            4'd1:    len = leap ? 31'd2505600 : 31'd2419200;
            4'd3,
            4'd5,
            4'd8,
            4'd10:   len = 31'd2592000;
            default: len = 31'd2678400;
        endcase
        return len;
    endfunction

endpackage

>>> hw/rtl/epoch_seconds_to_calendar_date_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar_date_core: seconds since 1970 to calendar date
// Breaks a 31-bit epoch second count into year, month, day, hour, minute
// and second by repeated subtraction through one shared subtractor.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: i_valid / o_stall carry i_seconds_since_epoch. o_stall is
//   high while a conversion runs; a transfer happens when i_valid is high and
//   o_stall is low.
//   Output channel: o_valid / i_stall carry the six date and time fields.
//   Each step removes one whole year, month, day, hour or minute, or moves
//   on to the next phase; after the minute phase the result is loaded. The
//   single compare-and-subtract unit does every step; one conversion runs at
//   a time.
//   The next transfer can happen the cycle after a result is loaded.
//   The result sits in an output register, so a new input is taken as soon
//   as a conversion has moved its result there, even while it still waits.
//   When the receiver stalls with the output register full, a finished
//   conversion holds until the register frees up.
//   Reset (i_rst_n low, synchronous) returns to idle and drops any pending
//   result.
// ----------------------------------------------------------------------------
module epoch_seconds_to_calendar_date_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  epc_pkg::t_secs      i_seconds_since_epoch,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [7:0]          o_years_since_1900,
    output logic [3:0]          o_month_index,
    output logic [4:0]          o_day_of_month,
    output logic [4:0]          o_hour_of_day,
    output logic [5:0]          o_minute_of_hour,
    output logic [5:0]          o_second_of_minute
);
    import epc_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic       r_state, n_state;
    t_phase     r_phase, n_phase;
    t_secs      r_rem,   n_rem;
    logic [7:0] r_year,  n_year;
    logic [3:0] r_month, n_month;
    logic [4:0] r_day,   n_day;
    logic [4:0] r_hour,  n_hour;
    logic [5:0] r_min,   n_min;
    logic       r_out_valid, n_out_valid;

    logic [7:0] r_o_year;
    logic [3:0] r_o_month;
    logic [4:0] r_o_day;
    logic [4:0] r_o_hour;
    logic [5:0] r_o_min;
    logic [5:0] r_o_sec;

    t_len_sel w_sel;
    t_sub_res w_sub;
    logic     w_load;

    epc_len_sel u_len_sel (
        .i_phase (r_phase),
        .i_year  (r_year),
        .i_month (r_month),
        .o_sel   (w_sel)
    );

    epc_sub_unit u_sub_unit (
        .i_rem (r_rem),
        .i_sel (w_sel),
        .o_res (w_sub)
    );

    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_rem       = r_rem;
        n_year      = r_year;
        n_month     = r_month;
        n_day       = r_day;
        n_hour      = r_hour;
        n_min       = r_min;
        w_load      = 1'b0;
        n_out_valid = r_out_valid && i_stall;

        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_state = ST_RUN;
                    n_phase = PH_YEAR;
                    n_rem   = i_seconds_since_epoch;
                    n_year  = EPOCH_YEAR;
                    n_month = '0;
                    n_day   = '0;
                    n_hour  = '0;
                    n_min   = '0;
                end
            end
            ST_RUN: begin
                if (w_sub.take) begin
                    n_rem = w_sub.diff;
                    unique case (r_phase)
                        PH_YEAR:  n_year  = r_year + 8'd1;
                        PH_MONTH: n_month = r_month + 4'd1;
                        PH_DAY:   n_day   = r_day + 5'd1;
                        PH_HOUR:  n_hour  = r_hour + 5'd1;
                        default:  n_min   = r_min + 6'd1;
                    endcase
                end else if (r_phase != PH_MIN) begin
                    n_phase = r_phase + 3'd1;
                end else if (!r_out_valid || !i_stall) begin
                    // Hand the result over once the output register frees up
                    w_load      = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_phase <= n_phase;
        r_rem   <= n_rem;
        r_year  <= n_year;
        r_month <= n_month;
        r_day   <= n_day;
        r_hour  <= n_hour;
        r_min   <= n_min;
        if (w_load) begin
            r_o_year  <= r_year;
            r_o_month <= r_month;
            r_o_day   <= r_day + 5'd1;
            r_o_hour  <= r_hour;
            r_o_min   <= r_min;
            r_o_sec   <= r_rem[5:0];
        end
    end

    assign o_stall            = (r_state != ST_IDLE);
    assign o_valid            = r_out_valid;
    assign o_years_since_1900 = r_o_year;
    assign o_month_index      = r_o_month;
    assign o_day_of_month     = r_o_day;
    assign o_hour_of_day      = r_o_hour;
    assign o_minute_of_hour   = r_o_min;
    assign o_second_of_minute = r_o_sec;

`ifndef ASSERT_OFF
    a_start_epoch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> (r_state == ST_RUN && r_phase == PH_YEAR &&
                                   r_year == EPOCH_YEAR))
        else $error("conversion did not start at the epoch year");

    a_rem_below_day: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN && (r_phase == PH_HOUR || r_phase == PH_MIN))
            |-> (r_rem < SECS_PER_DAY))
        else $error("remainder reached time of day phases above one day");

    a_result_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> (o_month_index <= MONTH_LAST && o_day_of_month != 5'd0 &&
                            o_hour_of_day <= 5'd23 && o_minute_of_hour <= 6'd59 &&
                            o_second_of_minute <= 6'd59))
        else $error("result field out of range");

    a_load_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> (o_valid && r_state == ST_IDLE))
        else $error("finished conversion did not reach the output register");
`endif

endmodule

>>> hw/rtl/epc_sub_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epc_sub_unit: shared compare-and-subtract unit
// Takes one unit length off the remaining seconds when it is allowed and fits.
// ----------------------------------------------------------------------------
module epc_sub_unit (
    input  epc_pkg::t_secs    i_rem,
    input  epc_pkg::t_len_sel i_sel,
    output epc_pkg::t_sub_res o_res
);
    import epc_pkg::*;

    logic [SecW:0] w_diff;

    assign w_diff     = {1'b0, i_rem} - {1'b0, i_sel.len};
    // No borrow means rem >= len
    assign o_res.take = i_sel.allow && !w_diff[SecW];
    assign o_res.diff = w_diff[SecW-1:0];

endmodule

>>> hw/rtl/epc_len_sel.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epc_len_sel: unit length selection
// Picks the length of the next year, month, day, hour or minute to remove.
// ----------------------------------------------------------------------------
module epc_len_sel (
    input  epc_pkg::t_phase   i_phase,
    input  logic [7:0]        i_year,
    input  logic [3:0]        i_month,
    output epc_pkg::t_len_sel o_sel
);
    import epc_pkg::*;

    logic w_leap;

    assign w_leap = leap_of(i_year);

    always_comb begin
        o_sel.len   = SECS_PER_MIN;
        o_sel.allow = 1'b0;
        unique case (i_phase)
            PH_YEAR: begin
                o_sel.len   = w_leap ? SECS_LEAP_YEAR : SECS_YEAR;
                o_sel.allow = 1'b1;
            end
            PH_MONTH: begin
                // December absorbs whatever is left of the year
                o_sel.len   = month_secs(i_month, w_leap);
                o_sel.allow = (i_month < MONTH_LAST);
            end
            PH_DAY: begin
                o_sel.len   = SECS_PER_DAY;
                o_sel.allow = 1'b1;
            end
            PH_HOUR: begin
                o_sel.len   = SECS_PER_HOUR;
                o_sel.allow = 1'b1;
            end
            PH_MIN: begin
                o_sel.len   = SECS_PER_MIN;
                o_sel.allow = 1'b1;
            end
            default: begin
                o_sel.len   = SECS_PER_MIN;
                o_sel.allow = 1'b0;
            end
        endcase
    end

endmodule

>>> tb/sv/calendar_date_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// calendar_date_checker: scoreboard for the epoch-to-calendar converter
// Watches the input and result channels, works out the calendar date of
// every accepted second count and compares each result transfer, field by
// field, with the oldest outstanding date. Hands back the mismatch count and
// the number of dates still outstanding.
// ----------------------------------------------------------------------------
module calendar_date_checker (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_in_stall,
    input  epc_pkg::t_secs i_in_secs,
    input  logic           i_out_valid,
    input  logic           i_out_stall,
    input  logic [7:0]     i_years_since_1900,
    input  logic [3:0]     i_month_index,
    input  logic [4:0]     i_day_of_month,
    input  logic [4:0]     i_hour_of_day,
    input  logic [5:0]     i_minute_of_hour,
    input  logic [5:0]     i_second_of_minute,
    output int unsigned    o_mismatches,
    output int unsigned    o_pending
);

    localparam int unsigned MINUTE_SECS  = 60;
    localparam int unsigned HOUR_SECS    = 3600;
    localparam int unsigned DAY_SECS     = 86400;
    localparam int unsigned FIRST_YEAR   = 70;
    localparam int unsigned CENTURY_BASE = 1900;
    localparam int unsigned LAST_MONTH   = 11;
    localparam int unsigned FEBRUARY     = 1;
    localparam int unsigned APRIL        = 3;
    localparam int unsigned JUNE         = 5;
    localparam int unsigned SEPTEMBER    = 8;
    localparam int unsigned NOVEMBER     = 10;

    typedef struct packed {
        logic [7:0] years;
        logic [3:0] month;
        logic [4:0] day;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
    } t_date_fields;

    typedef struct packed {
        epc_pkg::t_secs secs;
        t_date_fields   date;
    } t_expected_date;

    t_expected_date expected_dates[$];
    int unsigned    mismatch_count;

    function automatic logic leap_year(input int unsigned full_year);
        return (full_year % 400 == 0) || ((full_year % 4 == 0) && (full_year % 100 != 0));
    endfunction

    function automatic int unsigned year_secs(input int unsigned years_since_base);
        return (leap_year(CENTURY_BASE + years_since_base) ? 366 : 365) * DAY_SECS;
    endfunction

    function automatic int unsigned month_secs(input int unsigned mon, input logic leap);
        int unsigned days;
        case (mon)
            FEBRUARY:                           days = leap ? 29 : 28;
            APRIL, JUNE, SEPTEMBER, NOVEMBER:   days = 30;
            default:                            days = 31;
        endcase
        return days * DAY_SECS;
    endfunction

    function automatic t_date_fields civil_date_of(input epc_pkg::t_secs secs);
        int unsigned  left;
        int unsigned  year;
        int unsigned  mon;
        logic         leap;
        t_date_fields d;
        left = 32'(secs);
        year = FIRST_YEAR;
        mon  = 0;
        // peel off whole years, a remainder equal to a year rolls over
        while (left >= year_secs(year)) begin
            left -= year_secs(year);
            year++;
        end
        leap = leap_year(CENTURY_BASE + year);
        while (mon < LAST_MONTH && left >= month_secs(mon, leap)) begin
            left -= month_secs(mon, leap);
            mon++;
        end
        d.years  = 8'(year);
        d.month  = 4'(mon);
        d.day    = 5'(left / DAY_SECS + 1);
        left     = left % DAY_SECS;
        d.hour   = 5'(left / HOUR_SECS);
        left     = left % HOUR_SECS;
        d.minute = 6'(left / MINUTE_SECS);
        d.second = 6'(left % MINUTE_SECS);
        return d;
    endfunction

    task automatic check_field(input string name, input epc_pkg::t_secs secs,
                               input int unsigned want, input int unsigned got);
        if (want != got) begin
            $display("%0t: input %0d s, %s expected %0d, got %0d", $time, secs, name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_expected_date arrival;
        t_expected_date head;
        if (!i_rst_n) begin
            expected_dates.delete();
        end else begin
            if (i_in_valid && !i_in_stall) begin
                arrival.secs = i_in_secs;
                arrival.date = civil_date_of(i_in_secs);
                expected_dates.push_back(arrival);
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_dates.size() == 0) begin
                    $display("%0t: result transfer with no conversion outstanding", $time);
                    mismatch_count++;
                end else begin
                    head = expected_dates.pop_front();
                    check_field("year", head.secs, 32'(head.date.years),
                                32'(i_years_since_1900));
                    check_field("month", head.secs, 32'(head.date.month),
                                32'(i_month_index));
                    check_field("day", head.secs, 32'(head.date.day),
                                32'(i_day_of_month));
                    check_field("hour", head.secs, 32'(head.date.hour),
                                32'(i_hour_of_day));
                    check_field("minute", head.secs, 32'(head.date.minute),
                                32'(i_minute_of_hour));
                    check_field("second", head.secs, 32'(head.date.second),
                                32'(i_second_of_minute));
                end
            end
        end
        o_mismatches <= mismatch_count;
        o_pending    <= 32'(expected_dates.size());
    end

endmodule

>>> tb/sv/tb_epoch_seconds_to_calendar_date_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_epoch_seconds_to_calendar_date_core: converter testbench top
// Drives second counts into the converter: boundary values first, then
// random counts biased toward day, month and year edges. Idling moves from
// a stalling receiver to a slow sender to full rate, with one long receiver
// hold-off that backs the block up. The checker reports the verdict inputs.
// ----------------------------------------------------------------------------
module tb_epoch_seconds_to_calendar_date_core;

    localparam int unsigned RANDOM_PER_PHASE = 283;
    localparam int unsigned HOLD_CYCLES      = 600;
    localparam int unsigned DRAIN_CYCLES     = 300;
    localparam int unsigned MAX_DAY_INDEX    = 24855;
    localparam int unsigned DAY_SECS         = 86400;
    localparam longint unsigned MAX_SECS     = 64'h7FFF_FFFF;

    logic           i_clk = 1'b0;
    logic           i_rst_n = 1'b0;
    logic           i_valid = 1'b0;
    logic           o_stall;
    epc_pkg::t_secs i_seconds_since_epoch = '0;
    logic           o_valid;
    logic           i_stall = 1'b0;
    logic [7:0]     o_years_since_1900;
    logic [3:0]     o_month_index;
    logic [4:0]     o_day_of_month;
    logic [4:0]     o_hour_of_day;
    logic [5:0]     o_minute_of_hour;
    logic [5:0]     o_second_of_minute;

    int unsigned    n_mismatches;
    int unsigned    n_pending;
    int unsigned    send_idle_pct = 17;
    int unsigned    recv_stall_pct = 80;
    bit             hold_request = 1'b0;
    bit             hold_done = 1'b0;
    int unsigned    hold_left = 0;

    epoch_seconds_to_calendar_date_core dut (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_valid               (i_valid),
        .o_stall               (o_stall),
        .i_seconds_since_epoch (i_seconds_since_epoch),
        .o_valid               (o_valid),
        .i_stall               (i_stall),
        .o_years_since_1900    (o_years_since_1900),
        .o_month_index         (o_month_index),
        .o_day_of_month        (o_day_of_month),
        .o_hour_of_day         (o_hour_of_day),
        .o_minute_of_hour      (o_minute_of_hour),
        .o_second_of_minute    (o_second_of_minute)
    );

    calendar_date_checker date_checker (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_valid),
        .i_in_stall         (o_stall),
        .i_in_secs          (i_seconds_since_epoch),
        .i_out_valid        (o_valid),
        .i_out_stall        (i_stall),
        .i_years_since_1900 (o_years_since_1900),
        .i_month_index      (o_month_index),
        .i_day_of_month     (o_day_of_month),
        .i_hour_of_day      (o_hour_of_day),
        .i_minute_of_hour   (o_minute_of_hour),
        .i_second_of_minute (o_second_of_minute),
        .o_mismatches       (n_mismatches),
        .o_pending          (n_pending)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Receiver: random stalls, plus one long hold-off once requested
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            i_stall   <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (hold_request && !hold_done) begin
            i_stall   <= 1'b1;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Random counts: uniform, near day and year edges, near the top, near zero
    function automatic epc_pkg::t_secs random_epoch_secs();
        longint unsigned pick;
        int unsigned     kind;
        int unsigned     days;
        int unsigned     yr;
        int unsigned     y;
        kind = $urandom_range(9);
        days = 0;
        if (kind < 4) begin
            pick = 64'($urandom() & 32'h7FFF_FFFF);
        end else if (kind == 8) begin
            pick = MAX_SECS - 64'($urandom_range(200000));
        end else if (kind == 9) begin
            pick = 64'($urandom_range(100000));
        end else begin
            if (kind == 7) begin
                // every year divisible by four is leap within 1970..2037
                yr = $urandom_range(2037, 1970);
                for (y = 1970; y < yr; y++)
                    days += (y % 4 == 0) ? 366 : 365;
                case ($urandom_range(5))
                    0: days += 0;
                    1: days += 58;
                    2: days += 59;
                    3: days += 60;
                    4: days += 364;
                    default: days += 365;
                endcase
            end else begin
                days = $urandom_range(MAX_DAY_INDEX);
            end
            pick = 64'(days) * 64'(DAY_SECS);
            case ($urandom_range(3))
                0: pick = pick;
                1: pick = pick + 64'(DAY_SECS) - 64'd1;
                2: pick = pick + 64'($urandom_range(DAY_SECS - 1));
                default: if (pick != 0) pick = pick - 64'd1;
            endcase
        end
        if (pick > MAX_SECS)
            pick = MAX_SECS;
        return pick[30:0];
    endfunction

    task automatic offer_seconds(input epc_pkg::t_secs secs);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid               <= 1'b1;
        i_seconds_since_epoch <= secs;
        do @(posedge i_clk); while (o_stall);
    endtask

    initial begin : stimulus
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // zero, minute, hour and day edges
        offer_seconds(31'd0);
        offer_seconds(31'd59);
        offer_seconds(31'd60);
        offer_seconds(31'd3599);
        offer_seconds(31'd3600);
        offer_seconds(31'd86399);
        offer_seconds(31'd86400);
        // month and year edges in 1970
        offer_seconds(31'd2678399);
        offer_seconds(31'd2678400);
        offer_seconds(31'd31535999);
        offer_seconds(31'd31536000);
        // leap day of 1972 and the day after
        offer_seconds(31'd68169600);
        offer_seconds(31'd68255999);
        offer_seconds(31'd68256000);
        // leap century 2000, its last second and the next year
        offer_seconds(31'd951782400);
        offer_seconds(31'd978307199);
        offer_seconds(31'd978307200);
        offer_seconds(31'd1000000000);
        // last day reachable and the all-ones count
        offer_seconds(31'd2147472000);
        offer_seconds(31'd2147483646);
        offer_seconds(31'h7FFF_FFFF);

        repeat (RANDOM_PER_PHASE) offer_seconds(random_epoch_secs());

        send_idle_pct  = 80;
        recv_stall_pct = 17;
        repeat (RANDOM_PER_PHASE) offer_seconds(random_epoch_secs());

        // full rate, opened by a long receiver hold-off
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_request   = 1'b1;
        repeat (RANDOM_PER_PHASE) offer_seconds(random_epoch_secs());
        i_valid <= 1'b0;

        @(posedge i_clk);
        while (n_pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (n_mismatches == 0 && n_pending == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin : watchdog
        #20_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
